// ===== rtl/pi_pkg.sv =====
// Shared types, constants and fixed-point helpers of the particle integrator.
package pi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int WIDE_W    = 2 * WORD_BITS + 2;
  localparam int FIELD_W   = 32;
  localparam int ACT_W     = 3;
  localparam int IDX_W     = 3;
  localparam int NUM_AXES  = 3;
  localparam int IMASS_W   = 31;
  localparam int DT_W      = 17;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [WIDE_W-1:0]    wide_t;
  typedef logic signed [FIELD_W-1:0]   field_t;

  localparam logic [ACT_W-1:0] ACT_STEP    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FORCE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_IMPULSE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET_POS = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SET_VEL = 3'd4;

  localparam logic [IDX_W-1:0] REG_INV_MASS = 3'd0;
  localparam logic [IDX_W-1:0] REG_ACCEL_X  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ACCEL_Y  = 3'd2;
  localparam logic [IDX_W-1:0] REG_ACCEL_Z  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIME_STEP = 3'd4;
  localparam logic [IDX_W-1:0] REG_DAMPING  = 3'd5;

  localparam logic [DT_W-1:0] DAMPING_RESET = DT_W'(65536);

  localparam wide_t WORD_MAX_W = (wide_t'(1) <<< (WORD_BITS - 1)) - wide_t'(1);
  localparam wide_t WORD_MIN_W = -WORD_MAX_W - wide_t'(1);
  localparam wide_t OUT_MAX_W  = (wide_t'(1) <<< (FIELD_W - 1)) - wide_t'(1);
  localparam wide_t OUT_MIN_W  = -OUT_MAX_W - wide_t'(1);
  localparam prod_t RND_HALF   = prod_t'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic             mul1;
    logic             add1;
    logic             mul2;
    logic             add2;
    logic             mul3;
    logic             add3;
    logic             mul4;
    logic             add4;
    logic [ACT_W-1:0] action;
  } lane_cmd_t;

  function automatic word_t sat_word(wide_t v);
    word_t r;
    if (v > WORD_MAX_W) begin
      r = WORD_MAX_W[WORD_BITS-1:0];
    end else if (v < WORD_MIN_W) begin
      r = WORD_MIN_W[WORD_BITS-1:0];
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic word_t add_sat(word_t a, word_t b);
    return sat_word(wide_t'(a) + wide_t'(b));
  endfunction

  // product already carries the rounding half
  function automatic word_t rnd_word(prod_t p);
    prod_t s;
    s = p >>> FRAC_BITS;
    return sat_word(wide_t'(s));
  endfunction

  function automatic field_t sat_out(word_t w);
    wide_t  v;
    field_t r;
    v = wide_t'(w);
    if (v > OUT_MAX_W) begin
      r = OUT_MAX_W[FIELD_W-1:0];
    end else if (v < OUT_MIN_W) begin
      r = OUT_MIN_W[FIELD_W-1:0];
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pi_in_if.sv =====
// Request channel interface: action and operand vector.
interface pi_in_if;
  logic                             valid;
  logic                             ready;
  logic [pi_pkg::ACT_W-1:0]         action;
  logic signed [pi_pkg::FIELD_W-1:0] vec_x;
  logic signed [pi_pkg::FIELD_W-1:0] vec_y;
  logic signed [pi_pkg::FIELD_W-1:0] vec_z;

  modport source (output valid, action, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, action, vec_x, vec_y, vec_z, output ready);
endinterface

// ===== rtl/pi_out_if.sv =====
// Result channel interface: position and velocity after each request.
interface pi_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pi_pkg::FIELD_W-1:0] pos_x;
  logic signed [pi_pkg::FIELD_W-1:0] pos_y;
  logic signed [pi_pkg::FIELD_W-1:0] pos_z;
  logic signed [pi_pkg::FIELD_W-1:0] vel_x;
  logic signed [pi_pkg::FIELD_W-1:0] vel_y;
  logic signed [pi_pkg::FIELD_W-1:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

// ===== rtl/pi_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
interface pi_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pi_pkg::IDX_W-1:0]   index;
  logic [pi_pkg::FIELD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/particle_integrator_core.sv =====
// Top level of the particle integrator: configuration, sequencer, axis lanes, merge.
// Three axis lanes run in lockstep, each with its own multiplier; one request is in
// work at a time. A step runs four multiply and saturating-accumulate pairs per lane
// (force times inverse mass, times time step, damping, position advance), each a
// multiply state and an accumulate state, between the accept and load states. An
// impulse runs one such pair; add force, set position and set velocity run only the
// accumulate; a step on an immovable particle or an unknown action goes straight to
// the load state. The result register frees the request side, so the next request is
// taken while a result waits. Configuration writes are taken every cycle.
module particle_integrator_core (
  input  logic     clk,
  input  logic     rst_n,
  pi_in_if.sink    in_ch,
  pi_out_if.source out_ch,
  pi_cfg_if.sink   cfg_ch
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL1 = 10'b0000000010,
    S_ADD1 = 10'b0000000100,
    S_MUL2 = 10'b0000001000,
    S_ADD2 = 10'b0000010000,
    S_MUL3 = 10'b0000100000,
    S_ADD3 = 10'b0001000000,
    S_MUL4 = 10'b0010000000,
    S_ADD4 = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [pi_pkg::IMASS_W-1:0] imass_r;
  pi_pkg::field_t             accel_r [pi_pkg::NUM_AXES];
  logic [pi_pkg::DT_W-1:0]    dt_r;
  logic [pi_pkg::DT_W-1:0]    damp_r;

  logic [pi_pkg::ACT_W-1:0] action_r;
  pi_pkg::word_t            vec_r [pi_pkg::NUM_AXES];

  pi_pkg::word_t     imass_w, dt_w, damp_w;
  pi_pkg::word_t     accel_w [pi_pkg::NUM_AXES];
  pi_pkg::word_t     pos_w [pi_pkg::NUM_AXES];
  pi_pkg::word_t     vel_w [pi_pkg::NUM_AXES];
  pi_pkg::lane_cmd_t cmd;
  logic              in_acc;
  logic              merge_load;
  logic              merge_free;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imass_r <= '0;
      dt_r    <= '0;
      damp_r  <= pi_pkg::DAMPING_RESET;
      for (int i = 0; i < pi_pkg::NUM_AXES; i++) begin
        accel_r[i] <= '0;
      end
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pi_pkg::REG_INV_MASS:  imass_r    <= cfg_ch.data[pi_pkg::IMASS_W-1:0];
        pi_pkg::REG_ACCEL_X:   accel_r[0] <= cfg_ch.data;
        pi_pkg::REG_ACCEL_Y:   accel_r[1] <= cfg_ch.data;
        pi_pkg::REG_ACCEL_Z:   accel_r[2] <= cfg_ch.data;
        pi_pkg::REG_TIME_STEP: dt_r       <= cfg_ch.data[pi_pkg::DT_W-1:0];
        pi_pkg::REG_DAMPING:   damp_r     <= cfg_ch.data[pi_pkg::DT_W-1:0];
        default:               imass_r    <= imass_r;
      endcase
    end
  end

  assign imass_w = pi_pkg::sat_word(pi_pkg::wide_t'($signed({1'b0, imass_r})));
  assign dt_w    = pi_pkg::sat_word(pi_pkg::wide_t'($signed({1'b0, dt_r})));
  assign damp_w  = pi_pkg::sat_word(pi_pkg::wide_t'($signed({1'b0, damp_r})));

  always_comb begin
    for (int i = 0; i < pi_pkg::NUM_AXES; i++) begin
      accel_w[i] = pi_pkg::sat_word(pi_pkg::wide_t'(accel_r[i]));
    end
  end

  // request capture
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= in_ch.action;
      vec_r[0] <= pi_pkg::sat_word(pi_pkg::wide_t'(in_ch.vec_x));
      vec_r[1] <= pi_pkg::sat_word(pi_pkg::wide_t'(in_ch.vec_y));
      vec_r[2] <= pi_pkg::sat_word(pi_pkg::wide_t'(in_ch.vec_z));
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.action)
            pi_pkg::ACT_STEP:    state_nxt = (imass_r != '0) ? S_MUL1 : S_DONE;
            pi_pkg::ACT_IMPULSE: state_nxt = S_MUL1;
            pi_pkg::ACT_FORCE:   state_nxt = S_ADD1;
            pi_pkg::ACT_SET_POS: state_nxt = S_ADD1;
            pi_pkg::ACT_SET_VEL: state_nxt = S_ADD1;
            default:             state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL1: state_nxt = S_ADD1;
      S_ADD1: state_nxt = (action_r == pi_pkg::ACT_STEP) ? S_MUL2 : S_DONE;
      S_MUL2: state_nxt = S_ADD2;
      S_ADD2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_ADD3;
      S_ADD3: state_nxt = S_MUL4;
      S_MUL4: state_nxt = S_ADD4;
      S_ADD4: state_nxt = S_DONE;
      S_DONE: begin
        if (merge_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.mul1   = (state_r == S_MUL1);
  assign cmd.add1   = (state_r == S_ADD1);
  assign cmd.mul2   = (state_r == S_MUL2);
  assign cmd.add2   = (state_r == S_ADD2);
  assign cmd.mul3   = (state_r == S_MUL3);
  assign cmd.add3   = (state_r == S_ADD3);
  assign cmd.mul4   = (state_r == S_MUL4);
  assign cmd.add4   = (state_r == S_ADD4);
  assign cmd.action = action_r;

  for (genvar g = 0; g < pi_pkg::NUM_AXES; g++) begin : g_lane
    pi_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .accel (accel_w[g]),
      .imass (imass_w),
      .dt    (dt_w),
      .damp  (damp_w),
      .vec   (vec_r[g]),
      .pos   (pos_w[g]),
      .vel   (vel_w[g])
    );
  end

  assign merge_load = (state_r == S_DONE) && merge_free;

  pi_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (merge_load),
    .free   (merge_free),
    .pos_w  (pos_w),
    .vel_w  (vel_w),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted request did not start work");

  a_immovable_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.action == pi_pkg::ACT_STEP && imass_r == '0 |=> state_r == S_DONE)
    else $error("step on immovable particle entered the datapath");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    merge_load |=> out_ch.valid)
    else $error("result load did not raise out valid");

  a_step_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD4 |=> state_r == S_DONE && $past(action_r) == pi_pkg::ACT_STEP)
    else $error("step sequence broken");
`endif

endmodule

// ===== rtl/pi_lane.sv =====
// One axis lane: state words, one multiplier and the saturating accumulate.
module pi_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  pi_pkg::lane_cmd_t cmd,
  input  pi_pkg::word_t     accel,
  input  pi_pkg::word_t     imass,
  input  pi_pkg::word_t     dt,
  input  pi_pkg::word_t     damp,
  input  pi_pkg::word_t     vec,
  output pi_pkg::word_t     pos,
  output pi_pkg::word_t     vel
);

  pi_pkg::word_t pos_r, pos_nxt;
  pi_pkg::word_t vel_r, vel_nxt;
  pi_pkg::word_t frc_r, frc_nxt;
  pi_pkg::word_t tmp_r, tmp_nxt;
  pi_pkg::prod_t prod_r, prod_nxt;
  pi_pkg::word_t mul_a, mul_b;
  pi_pkg::word_t rnd;
  logic          mul_en;

  assign mul_en = cmd.mul1 | cmd.mul2 | cmd.mul3 | cmd.mul4;
  assign rnd    = pi_pkg::rnd_word(prod_r);

  always_comb begin
    mul_a = tmp_r;
    mul_b = dt;
    if (cmd.mul1) begin
      mul_a = (cmd.action == pi_pkg::ACT_STEP) ? frc_r : vec;
      mul_b = imass;
    end else if (cmd.mul3) begin
      mul_b = damp;
    end else if (cmd.mul4) begin
      mul_a = vel_r;
    end
    prod_nxt = pi_pkg::prod_t'(mul_a) * pi_pkg::prod_t'(mul_b) + pi_pkg::RND_HALF;
  end

  always_comb begin
    pos_nxt = pos_r;
    vel_nxt = vel_r;
    frc_nxt = frc_r;
    tmp_nxt = tmp_r;
    if (cmd.add1) begin
      case (cmd.action)
        pi_pkg::ACT_STEP:    tmp_nxt = pi_pkg::add_sat(accel, rnd);
        pi_pkg::ACT_FORCE:   frc_nxt = pi_pkg::add_sat(frc_r, vec);
        pi_pkg::ACT_IMPULSE: vel_nxt = pi_pkg::add_sat(vel_r, rnd);
        pi_pkg::ACT_SET_POS: pos_nxt = vec;
        pi_pkg::ACT_SET_VEL: vel_nxt = vec;
        default:             tmp_nxt = tmp_r;
      endcase
    end else if (cmd.add2) begin
      tmp_nxt = pi_pkg::add_sat(vel_r, rnd);
    end else if (cmd.add3) begin
      vel_nxt = rnd;
    end else if (cmd.add4) begin
      pos_nxt = pi_pkg::add_sat(pos_r, rnd);
      frc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vel_r <= '0;
      frc_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      vel_r <= vel_nxt;
      frc_r <= frc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tmp_r <= tmp_nxt;
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign pos = pos_r;
  assign vel = vel_r;

endmodule

// ===== rtl/pi_merge.sv =====
// Merge stage: gathers the lane words, saturates them and holds the result.
module pi_merge (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  output logic          free,
  input  pi_pkg::word_t pos_w [pi_pkg::NUM_AXES],
  input  pi_pkg::word_t vel_w [pi_pkg::NUM_AXES],
  pi_out_if.source      out_ch
);

  logic           valid_r, valid_nxt;
  pi_pkg::field_t pos_r [pi_pkg::NUM_AXES];
  pi_pkg::field_t vel_r [pi_pkg::NUM_AXES];

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < pi_pkg::NUM_AXES; i++) begin
        pos_r[i] <= pi_pkg::sat_out(pos_w[i]);
        vel_r[i] <= pi_pkg::sat_out(vel_w[i]);
      end
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.pos_x = pos_r[0];
  assign out_ch.pos_y = pos_r[1];
  assign out_ch.pos_z = pos_r[2];
  assign out_ch.vel_x = vel_r[0];
  assign out_ch.vel_y = vel_r[1];
  assign out_ch.vel_z = vel_r[2];

endmodule

// ===== test/particle_integrator_core_tb.sv =====
// Testbench for particle_integrator_core: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module particle_integrator_core_tb;

  typedef logic [pi_pkg::ACT_W-1:0] act_t;
  typedef logic [pi_pkg::IDX_W-1:0] idx_t;

  localparam act_t ACT_UNDEF_LO = 3'd5;
  localparam act_t ACT_UNDEF_HI = 3'd7;
  localparam idx_t REG_SPARE_LO = 3'd6;
  localparam idx_t REG_SPARE_HI = 3'd7;
  localparam pi_pkg::field_t FIELD_MAX = 32'sh7FFFFFFF;
  localparam pi_pkg::field_t FIELD_MIN = 32'sh80000000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -Q_MAX - 64'sd1;
  localparam longint Q_HALF = 64'sd32768;

  typedef logic [5:0][pi_pkg::FIELD_W-1:0] motion_t;

  logic clk;
  logic rst_n;

  pi_in_if  in_ch ();
  pi_out_if out_ch ();
  pi_cfg_if cfg_ch ();

  particle_integrator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  longint particle_pos [3];
  longint particle_vel [3];
  longint force_acc [3];
  longint accel_cfg [3];
  logic [pi_pkg::IMASS_W-1:0] inv_mass;
  logic [pi_pkg::DT_W-1:0] dt_cfg;
  logic [pi_pkg::DT_W-1:0] damp_cfg;

  motion_t expected_motion [$];
  int mismatches = 0;
  int burst_left = 0;
  string field_names [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("particle_integrator_core_tb: FAIL");
    $finish;
  end

  function automatic longint sat_q16(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    longint p;
    p = a * b + Q_HALF;
    return sat_q16(p >>> pi_pkg::FRAC_BITS);
  endfunction

  function automatic void clear_particle();
    for (int i = 0; i < 3; i++) begin
      particle_pos[i] = 0;
      particle_vel[i] = 0;
      force_acc[i] = 0;
      accel_cfg[i] = 0;
    end
    inv_mass = '0;
    dt_cfg = '0;
    damp_cfg = pi_pkg::DAMPING_RESET;
  endfunction

  function automatic motion_t apply_request(act_t act, pi_pkg::field_t vx, pi_pkg::field_t vy,
                                            pi_pkg::field_t vz);
    longint vec [3];
    longint acc_now;
    longint vel_now;
    motion_t res;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    for (int i = 0; i < 3; i++) begin
      case (act)
        pi_pkg::ACT_STEP: begin
          if (inv_mass != 0) begin
            acc_now = sat_q16(accel_cfg[i] + mul_q16(force_acc[i], longint'(inv_mass)));
            vel_now = sat_q16(particle_vel[i] + mul_q16(acc_now, longint'(dt_cfg)));
            vel_now = mul_q16(vel_now, longint'(damp_cfg));
            particle_vel[i] = vel_now;
            particle_pos[i] = sat_q16(particle_pos[i] + mul_q16(vel_now, longint'(dt_cfg)));
            force_acc[i] = 0;
          end
        end
        pi_pkg::ACT_FORCE: force_acc[i] = sat_q16(force_acc[i] + vec[i]);
        pi_pkg::ACT_IMPULSE: begin
          particle_vel[i] = sat_q16(particle_vel[i] + mul_q16(vec[i], longint'(inv_mass)));
        end
        pi_pkg::ACT_SET_POS: particle_pos[i] = vec[i];
        pi_pkg::ACT_SET_VEL: particle_vel[i] = vec[i];
        default: ;
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      res[i] = particle_pos[i][pi_pkg::FIELD_W-1:0];
      res[3 + i] = particle_vel[i][pi_pkg::FIELD_W-1:0];
    end
    return res;
  endfunction

  // receiver: rotate a stall mask, reload it now and then
  initial begin : ready_gen
    logic [15:0] stall_mask;
    int stall_left;
    stall_left = 0;
    stall_mask = 16'hFFFF;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = 16'hFFFF;
          1: stall_mask = 16'hAAAA;
          2: stall_mask = 16'h8001;
          default: stall_mask = 16'($urandom) | 16'h0001;
        endcase
        stall_left = $urandom_range(16, 300);
      end else begin
        stall_left--;
      end
      stall_mask = {stall_mask[14:0], stall_mask[15]};
      out_ch.ready <= stall_mask[0];
    end
  end

  always @(posedge clk) begin : check_results
    motion_t want;
    motion_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.vel_z, out_ch.vel_y, out_ch.vel_x, out_ch.pos_z, out_ch.pos_y, out_ch.pos_x};
      if (expected_motion.size() == 0) begin
        $display("%0t: result with no request pending, pos_x %0d vel_x %0d", $time,
                 $signed(out_ch.pos_x), $signed(out_ch.vel_x));
        mismatches++;
      end else begin
        want = expected_motion.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (want[k] !== got[k]) begin
            $display("%0t: %s expected %0d actual %0d", $time, field_names[k],
                     $signed(want[k]), $signed(got[k]));
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_request(input act_t act, input pi_pkg::field_t vx,
                              input pi_pkg::field_t vy, input pi_pkg::field_t vz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.vec_x <= vx;
    in_ch.vec_y <= vy;
    in_ch.vec_z <= vz;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    expected_motion.push_back(apply_request(act, vx, vy, vz));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input idx_t idx, input logic [pi_pkg::FIELD_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      pi_pkg::REG_INV_MASS:  inv_mass = data[pi_pkg::IMASS_W-1:0];
      pi_pkg::REG_ACCEL_X:   accel_cfg[0] = $signed(data);
      pi_pkg::REG_ACCEL_Y:   accel_cfg[1] = $signed(data);
      pi_pkg::REG_ACCEL_Z:   accel_cfg[2] = $signed(data);
      pi_pkg::REG_TIME_STEP: dt_cfg = data[pi_pkg::DT_W-1:0];
      pi_pkg::REG_DAMPING:   damp_cfg = data[pi_pkg::DT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [pi_pkg::FIELD_W-1:0] im_w, input pi_pkg::field_t ax,
                               input pi_pkg::field_t ay, input pi_pkg::field_t az,
                               input logic [pi_pkg::FIELD_W-1:0] dt_w,
                               input logic [pi_pkg::FIELD_W-1:0] damp_w);
    write_reg(idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    write_reg(pi_pkg::REG_INV_MASS, im_w);
    write_reg(pi_pkg::REG_ACCEL_X, ax);
    write_reg(pi_pkg::REG_ACCEL_Y, ay);
    write_reg(pi_pkg::REG_ACCEL_Z, az);
    write_reg(pi_pkg::REG_TIME_STEP, dt_w);
    write_reg(pi_pkg::REG_DAMPING, damp_w);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic pi_pkg::field_t small_q16();
    return pi_pkg::field_t'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  function automatic pi_pkg::field_t rand_operand(bit wild);
    int pick;
    pick = $urandom_range(0, 9);
    if (!wild && pick < 3) pick = pick + 4;
    case (pick)
      0: return FIELD_MAX;
      1: return FIELD_MIN;
      2, 3: return pi_pkg::field_t'($urandom);
      default: return small_q16();
    endcase
  endfunction

  function automatic act_t rand_action();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return pi_pkg::ACT_STEP;
    if (roll < 65) return pi_pkg::ACT_FORCE;
    if (roll < 78) return pi_pkg::ACT_IMPULSE;
    if (roll < 86) return pi_pkg::ACT_SET_POS;
    if (roll < 94) return pi_pkg::ACT_SET_VEL;
    return act_t'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
  endfunction

  function automatic logic [pi_pkg::FIELD_W-1:0] wild_scale();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 32'd65536;
      2: return 32'h1FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_random_settings(input bit wild, input bit immovable);
    logic [pi_pkg::FIELD_W-1:0] im_w;
    logic [pi_pkg::FIELD_W-1:0] dt_w;
    logic [pi_pkg::FIELD_W-1:0] damp_w;
    if (immovable) begin
      im_w = '0;
    end else if (!wild) begin
      im_w = $urandom_range(1 << 14, 1 << 18);
    end else begin
      case ($urandom_range(0, 2))
        0: im_w = 32'h7FFFFFFF;
        1: im_w = $urandom_range(1, 255);
        default: im_w = $urandom;
      endcase
    end
    dt_w = wild ? wild_scale() : $urandom_range(256, 8192);
    damp_w = wild ? wild_scale() : $urandom_range(58000, 65536);
    if (wild) begin
      load_settings(im_w, rand_operand(1'b1), rand_operand(1'b1), rand_operand(1'b1), dt_w,
                    damp_w);
    end else begin
      load_settings(im_w, small_q16(), small_q16(), small_q16(), dt_w, damp_w);
    end
  endtask

  // immovable particle after reset: steps hold the force sum, impulses do nothing
  task automatic test_reset_defaults();
    send_request(pi_pkg::ACT_STEP, 32'sd0, 32'sd0, 32'sd0);
    send_request(pi_pkg::ACT_FORCE, FIELD_MAX, FIELD_MIN, 32'sd65536);
    send_request(pi_pkg::ACT_STEP, 32'sd1, 32'sd2, 32'sd3);
    send_request(pi_pkg::ACT_IMPULSE, FIELD_MAX, FIELD_MIN, FIELD_MAX);
    send_request(pi_pkg::ACT_SET_POS, FIELD_MIN, FIELD_MAX, -32'sd65536);
    for (int a = ACT_UNDEF_LO; a <= ACT_UNDEF_HI; a++) begin
      send_request(act_t'(a), FIELD_MAX, FIELD_MAX, FIELD_MAX);
    end
    drain();
  endtask

  task automatic test_saturation();
    load_settings(32'h7FFFFFFF, FIELD_MAX, FIELD_MIN, 32'sd0, 32'h1FFFF, 32'h1FFFF);
    send_request(pi_pkg::ACT_STEP, 32'sd0, 32'sd0, 32'sd0);
    send_request(pi_pkg::ACT_SET_POS, FIELD_MAX, FIELD_MIN, 32'sd0);
    send_request(pi_pkg::ACT_SET_VEL, FIELD_MIN, FIELD_MAX, 32'sd1);
    send_request(pi_pkg::ACT_FORCE, FIELD_MAX, FIELD_MAX, FIELD_MIN);
    send_request(pi_pkg::ACT_FORCE, FIELD_MAX, FIELD_MAX, FIELD_MIN);
    send_request(pi_pkg::ACT_STEP, 32'sd0, 32'sd0, 32'sd0);
    send_request(pi_pkg::ACT_IMPULSE, FIELD_MIN, FIELD_MAX, -32'sd1);
    send_request(pi_pkg::ACT_SET_VEL, 32'sd0, 32'sd0, 32'sd0);
    send_request(pi_pkg::ACT_FORCE, FIELD_MIN, FIELD_MIN, FIELD_MAX);
    send_request(pi_pkg::ACT_STEP, 32'sd0, 32'sd0, 32'sd0);
    drain();
    load_settings(32'd1, FIELD_MIN, FIELD_MAX, 32'sd65536, 32'd0, 32'd0);
    send_request(pi_pkg::ACT_FORCE, 32'sh12345678, -32'sh12345678, 32'sd32768);
    send_request(pi_pkg::ACT_STEP, 32'sd0, 32'sd0, 32'sd0);
    send_request(pi_pkg::ACT_IMPULSE, FIELD_MAX, FIELD_MIN, 32'sd32768);
    send_request(pi_pkg::ACT_STEP, 32'sd0, 32'sd0, 32'sd0);
    drain();
  endtask

  task automatic test_random_traffic();
    bit wild;
    for (int p = 0; p < 8; p++) begin
      wild = (p % 2) == 1;
      load_random_settings(wild, p == 5);
      for (int n = 0; n < 250; n++) begin
        send_request(rand_action(), rand_operand(wild), rand_operand(wild), rand_operand(wild));
      end
      drain();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= pi_pkg::ACT_STEP;
    in_ch.vec_x <= '0;
    in_ch.vec_y <= '0;
    in_ch.vec_z <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= pi_pkg::REG_INV_MASS;
    cfg_ch.data <= '0;
    clear_particle();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_saturation();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("particle_integrator_core_tb: PASS");
    end else begin
      $display("particle_integrator_core_tb: FAIL");
    end
    $finish;
  end

endmodule
